// ===== rtl/fpssf_pkg.sv =====
`default_nettype none

package fpssf_pkg;

    localparam int unsigned NumDigits = 4;

    localparam logic [7:0] SegDash  = 8'h40;
    localparam logic [7:0] SegPoint = 8'h80;
    localparam logic [7:0] SegBlank = 8'h00;

    // values at or above this limit show dashes
    localparam logic [14:0] LimitHund = 15'd10000;

    // u / 100 as (u * 5243) >> 19, exact for u below 10000
    localparam logic [12:0] Div100Mul   = 13'd5243;
    localparam int unsigned Div100Shift = 19;

    // result slot codes
    localparam logic [2:0] SlotDig3  = 3'd3;
    localparam logic [2:0] SlotBlank = 3'd4;

    localparam logic [3:0] SelDig3 = 4'b1000;

    typedef struct packed {
        logic [NumDigits-1:0][7:0] seg;
    } t_seg_set;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_dec_pair;

    // common-cathode segment patterns, bits 0-6 = a-g
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = SegBlank;
        endcase
        return s;
    endfunction

    // split 0..99 into two decimal digits; x/10 as (x * 205) >> 11
    function automatic t_dec_pair split_dec(input logic [6:0] x);
        logic [14:0] prod;
        logic [6:0]  t10;
        t_dec_pair   p;
        prod    = 15'(x) * 15'd205;
        p.tens  = prod[14:11];
        t10     = 7'(p.tens) * 7'd10;
        p.units = 4'(x - t10);
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fixed_point_seven_segment_formatter_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_value_hundredths (16b signed)
// result    out        o_out_valid / i_out_stall  o_digit_select, o_segments, o_last
//
// Three register stages (input, /100 quotient, segment set) ahead of a result
// sequencer; an accepted value passes all three before its first result.
// Each transaction yields 4 results (dashes) or 5 (digits plus blanking write),
// one per cycle while i_out_stall is low; the sequencer sets the sustained rate.
// Input is taken while earlier values are in flight or draining, if a stage is free.
// Reset (i_rst_n low, synchronous) empties all stages and the slot counter.
// A stalled result holds: payload comes only from registers and the counter.
module fixed_point_seven_segment_formatter_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire logic signed [15:0] i_value_hundredths,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      logic [3:0]         o_digit_select,
    output      logic [7:0]         o_segments,
    output      logic               o_last
);

    // stage 1: input register
    logic               r1_vld;
    logic signed [15:0] r1_val;

    // stage 2: range flag, value, quotient by 100
    logic               r2_vld;
    logic               r2_oor;
    logic [13:0]        r2_u;
    logic [6:0]         r2_q;

    // stage 3: segment set held while the sequencer walks it
    logic                 r3_vld;
    logic                 r3_oor;
    fpssf_pkg::t_seg_set  r3_segs;
    logic [2:0]           r_idx;

    logic                 s1_en;
    logic                 s2_en;
    logic                 s3_en;
    logic                 out_fire;
    logic                 out_done;
    logic [26:0]          div_prod;
    logic                 n_oor;
    fpssf_pkg::t_seg_set  n_segs;

    // stage enables: a stage loads when empty or when its occupant moves on
    assign out_fire = r3_vld && !i_out_stall;
    assign out_done = out_fire && o_last;
    assign s3_en    = !r3_vld || out_done;
    assign s2_en    = !r2_vld || s3_en;
    assign s1_en    = !r1_vld || s2_en;
    assign o_in_stall = !s1_en;

    // out of range: negative or 10000 and up
    assign n_oor    = r1_val[15] || (r1_val[14:0] >= fpssf_pkg::LimitHund);
    assign div_prod = 27'(r1_val[13:0]) * 27'(fpssf_pkg::Div100Mul);

    fpssf_digit_enc u_enc (
        .i_u    (r2_u),
        .i_q    (r2_q),
        .o_segs (n_segs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (s1_en) begin
                r1_vld <= i_in_valid;
            end
            if (s2_en) begin
                r2_vld <= r1_vld;
            end
            if (s3_en) begin
                r3_vld <= r2_vld;
            end
            if (out_done) begin
                r_idx <= '0;
            end else if (out_fire) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s1_en && i_in_valid) begin
            r1_val <= i_value_hundredths;
        end
        if (s2_en && r1_vld) begin
            r2_oor <= n_oor;
            r2_u   <= r1_val[13:0];
            r2_q   <= div_prod[fpssf_pkg::Div100Shift +: 7];
        end
        if (s3_en && r2_vld) begin
            r3_oor  <= r2_oor;
            r3_segs <= n_segs;
        end
    end

    // result mux: digits 0..3, then a blanking write to digit 3 unless dashes
    always_comb begin
        o_out_valid = r3_vld;
        if (r_idx == fpssf_pkg::SlotBlank) begin
            o_digit_select = fpssf_pkg::SelDig3;
        end else begin
            o_digit_select = 4'(4'b0001 << r_idx[1:0]);
        end
        if (r3_oor) begin
            o_segments = fpssf_pkg::SegDash;
            o_last     = (r_idx == fpssf_pkg::SlotDig3);
        end else begin
            o_segments = (r_idx == fpssf_pkg::SlotBlank) ? fpssf_pkg::SegBlank
                                                         : r3_segs.seg[r_idx[1:0]];
            o_last     = (r_idx == fpssf_pkg::SlotBlank);
        end
    end

    // the last result of a transaction always targets digit 3
    a_last_dig3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_digit_select == fpssf_pkg::SelDig3)
        else $error("last result not on digit 3");

    // a dash transaction never reaches the blanking slot
    a_dash_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld && r3_oor |-> r_idx <= fpssf_pkg::SlotDig3)
        else $error("dash sequence ran past digit 3");

    // slot counter restarts after a finished transaction
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done |=> r_idx == 3'd0)
        else $error("slot counter did not restart");

    // counter moves only on a delivered result
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_fire |=> $stable(r_idx))
        else $error("slot counter moved without a transaction");

endmodule

`default_nettype wire

// ===== rtl/fpssf_digit_enc.sv =====
`default_nettype none

// Remainder by 100, then both halves to decimal digits and segment bytes.
module fpssf_digit_enc (
    input  wire logic [13:0]        i_u,
    input  wire logic [6:0]         i_q,
    output fpssf_pkg::t_seg_set     o_segs
);

    logic [13:0]          q100;
    logic [13:0]          rem14;
    fpssf_pkg::t_dec_pair hi;
    fpssf_pkg::t_dec_pair lo;

    always_comb begin
        q100  = 14'(i_q) * 14'd100;
        rem14 = i_u - q100;
        hi    = fpssf_pkg::split_dec(i_q);
        lo    = fpssf_pkg::split_dec(rem14[6:0]);
        o_segs.seg[0] = fpssf_pkg::seg_of(hi.tens);
        o_segs.seg[1] = fpssf_pkg::seg_of(hi.units) | fpssf_pkg::SegPoint;
        o_segs.seg[2] = fpssf_pkg::seg_of(lo.tens);
        o_segs.seg[3] = fpssf_pkg::seg_of(lo.units);
    end

endmodule

`default_nettype wire
